[rtl/core/htfd_pkg.sv]
// Shared types and constants for the humidity and temperature frame decoder.
package htfd_pkg;

  // One received beat: a readout byte and the frame start marker.
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } htfd_in_t;

  // One decoded result beat.
  typedef struct packed {
    logic signed [11:0] temp_tenths;
    logic [9:0]         humidity_tenths;
    logic               crc_error;
  } htfd_out_t;

  // Raw words of a completed frame, handed from the frame tracker to the scaler.
  typedef struct packed {
    logic        good;
    logic [15:0] temp_raw;
    logic [15:0] hum_raw;
  } htfd_frame_t;

  // Byte positions inside one six-byte readout.
  localparam logic [2:0] POS_T_HI  = 3'd0;
  localparam logic [2:0] POS_T_LO  = 3'd1;
  localparam logic [2:0] POS_T_CRC = 3'd2;
  localparam logic [2:0] POS_H_HI  = 3'd3;
  localparam logic [2:0] POS_H_LO  = 3'd4;
  localparam logic [2:0] POS_H_CRC = 3'd5;

  // CRC-8 settings.
  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  // Conversion constants.
  localparam logic [10:0] TEMP_SCALE  = 11'd1750;
  localparam logic [9:0]  HUM_SCALE   = 10'd1000;
  localparam logic [15:0] ROUND_HALF  = 16'd32767;
  localparam logic [16:0] FULL_SCALE  = 17'd65535;
  localparam logic signed [11:0] TEMP_OFFSET = 12'sd450;

endpackage

[rtl/core/humidity_temp_frame_decoder_unit.sv]
// Top level of the CRC-checked humidity and temperature frame decoder.
// This block takes the six readout bytes of a humidity and temperature sensor,
// one byte per input beat, in the order temperature high, temperature low,
// temperature CRC, humidity high, humidity low, humidity CRC. Each CRC byte
// is checked against the CRC-8 (polynomial 0x31, seed 0xFF, MSB first) of the
// two bytes before it. After the sixth byte one result beat comes out with the
// temperature in tenths of a degree Celsius, the relative humidity in tenths
// of a percent and a CRC error flag; both values read zero when either check
// fails. A byte with frame_start set always counts as the first byte of a new
// frame and drops any partial frame; without it, frames may follow each other
// directly. Input bytes land in an input register; logic behind it updates the
// frame state and, on the sixth byte, scales the raw words into the output
// register. The block accepts one byte per cycle unless the input side stalls,
// and an accepted sixth byte passes from the input register into the output
// register as its result beat. The input side stalls only when a sixth byte
// waits in the input register while an earlier result is still held by a stalled output.
module humidity_temp_frame_decoder_unit
  import htfd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  htfd_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output htfd_out_t out_data
);

  // Input register.
  logic     s1_valid_r, s1_valid_nxt;
  htfd_in_t s1_data_r;

  // Output register.
  logic      out_valid_r, out_valid_nxt;
  htfd_out_t out_data_r;

  logic        in_take;
  logic        out_free;
  logic        s1_go;
  logic        emit;
  htfd_frame_t frame;
  htfd_out_t   scaled;

  htfd_frame u_frame (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (s1_go),
    .beat  (s1_data_r),
    .emit  (emit),
    .done  (frame)
  );

  htfd_scale u_scale (
    .frame  (frame),
    .result (scaled)
  );

  // The output register can take a new result when empty or being drained.
  assign out_free = !out_valid_r || !out_stall;

  // A byte that produces no result always moves on; the sixth byte needs room.
  assign s1_go    = s1_valid_r && (!emit || out_free);
  assign in_stall = s1_valid_r && !s1_go;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_go && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers load without reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data;
    end
    if (s1_go && emit) begin
      out_data_r <= scaled;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A failed check must zero both readings.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.crc_error |->
      (out_data_r.temp_tenths == 12'sd0) && (out_data_r.humidity_tenths == 10'd0))
    else $error("crc error result carries nonzero readings");

  // Good results stay within the sensor range.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.crc_error |->
      (out_data_r.temp_tenths >= -12'sd450) && (out_data_r.temp_tenths <= 12'sd1300) &&
      (out_data_r.humidity_tenths <= 10'd1000))
    else $error("decoded reading out of range");

  // The input side stalls only for a held sixth byte facing a blocked output.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && emit && out_valid_r && out_stall)
    else $error("input stalled without cause");

  // A sixth byte leaving the input register shows up as a result beat.
  a_emit_load: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && emit |=> out_valid_r)
    else $error("result beat lost");

endmodule

[rtl/core/htfd_crc8.sv]
// Byte-wide CRC-8 update, polynomial 0x31, MSB first.
module htfd_crc8
  import htfd_pkg::*;
(
  input  logic [7:0] crc_in,
  input  logic [7:0] data_in,
  output logic [7:0] crc_out
);

  always_comb begin
    logic [7:0] c;
    c = crc_in ^ data_in;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

[rtl/core/htfd_frame.sv]
// Frame position tracking, CRC accumulation and raw word capture.
module htfd_frame
  import htfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  htfd_in_t    beat,
  output logic        emit,
  output htfd_frame_t done
);

  logic [2:0]  pos_r, pos_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [15:0] temp_raw_r, temp_raw_nxt;
  logic        temp_good_r, temp_good_nxt;
  logic [7:0]  hum_hi_r, hum_hi_nxt;
  logic [7:0]  hum_lo_r, hum_lo_nxt;

  logic [2:0]  pos_cur;
  logic [7:0]  crc_seed;
  logic [7:0]  crc_upd;

  // A start marker forces byte zero; positions past the end restart the frame.
  always_comb begin
    if (beat.frame_start || pos_r > POS_H_CRC) begin
      pos_cur = POS_T_HI;
    end else begin
      pos_cur = pos_r;
    end
  end

  always_comb begin
    if (pos_cur inside {POS_T_HI, POS_H_HI}) begin
      crc_seed = CRC_INIT;
    end else begin
      crc_seed = crc_r;
    end
  end

  htfd_crc8 u_crc (
    .crc_in  (crc_seed),
    .data_in (beat.rx_byte),
    .crc_out (crc_upd)
  );

  assign emit      = (pos_cur == POS_H_CRC);
  assign done.good = temp_good_r && (crc_r == beat.rx_byte);
  assign done.temp_raw = temp_raw_r;
  assign done.hum_raw  = {hum_hi_r, hum_lo_r};

  always_comb begin
    pos_nxt       = pos_r;
    crc_nxt       = crc_r;
    temp_raw_nxt  = temp_raw_r;
    temp_good_nxt = temp_good_r;
    hum_hi_nxt    = hum_hi_r;
    hum_lo_nxt    = hum_lo_r;
    if (step) begin
      pos_nxt = (pos_cur >= POS_H_CRC) ? POS_T_HI : pos_cur + 3'd1;
      case (pos_cur)
        POS_T_HI: begin
          crc_nxt      = crc_upd;
          temp_raw_nxt = {beat.rx_byte, 8'd0};
        end
        POS_T_LO: begin
          crc_nxt      = crc_upd;
          temp_raw_nxt = {temp_raw_r[15:8], beat.rx_byte};
        end
        POS_T_CRC: begin
          temp_good_nxt = (crc_r == beat.rx_byte);
          crc_nxt       = CRC_INIT;
        end
        POS_H_HI: begin
          crc_nxt    = crc_upd;
          hum_hi_nxt = beat.rx_byte;
        end
        POS_H_LO: begin
          crc_nxt    = crc_upd;
          hum_lo_nxt = beat.rx_byte;
        end
        default: begin
          crc_nxt = CRC_INIT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= POS_T_HI;
      crc_r       <= CRC_INIT;
      temp_raw_r  <= 16'd0;
      temp_good_r <= 1'b0;
      hum_hi_r    <= 8'd0;
      hum_lo_r    <= 8'd0;
    end else begin
      pos_r       <= pos_nxt;
      crc_r       <= crc_nxt;
      temp_raw_r  <= temp_raw_nxt;
      temp_good_r <= temp_good_nxt;
      hum_hi_r    <= hum_hi_nxt;
      hum_lo_r    <= hum_lo_nxt;
    end
  end

endmodule

[rtl/core/htfd_scale.sv]
// Conversion of raw words to tenths of a degree and tenths of a percent.
module htfd_scale
  import htfd_pkg::*;
(
  input  htfd_frame_t frame,
  output htfd_out_t   result
);

  // Division by 65535: with x = a*65536 + b, x = a*65535 + (a + b), and a + b
  // stays below twice the divisor, so one compare finishes the quotient.
  logic [26:0] t_prod;
  logic [16:0] t_rem;
  logic [10:0] t_quot;
  logic [25:0] h_prod;
  logic [16:0] h_rem;
  logic [9:0]  h_quot;

  always_comb begin
    t_prod = TEMP_SCALE * frame.temp_raw + {11'd0, ROUND_HALF};
    t_rem  = {6'd0, t_prod[26:16]} + {1'b0, t_prod[15:0]};
    t_quot = t_prod[26:16] + {10'd0, (t_rem >= FULL_SCALE)};

    h_prod = HUM_SCALE * frame.hum_raw + {10'd0, ROUND_HALF};
    h_rem  = {7'd0, h_prod[25:16]} + {1'b0, h_prod[15:0]};
    h_quot = h_prod[25:16] + {9'd0, (h_rem >= FULL_SCALE)};

    if (frame.good) begin
      result.temp_tenths     = $signed({1'b0, t_quot}) - TEMP_OFFSET;
      result.humidity_tenths = h_quot;
      result.crc_error       = 1'b0;
    end else begin
      result.temp_tenths     = 12'sd0;
      result.humidity_tenths = 10'd0;
      result.crc_error       = 1'b1;
    end
  end

endmodule
